>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the console RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define TCW_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hw/rtl/tcw_pkg.sv
// Shared constants, codes and controller/datapath types of the text console.
package tcw_pkg;

    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

    // Port field widths.
    localparam int FUNC_FW = 2;
    localparam int CHAR_FW = 8;
    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;

    localparam logic [CHAR_FW-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_FW-1:0] CH_MARK  = 8'h5F;

    typedef enum logic [FUNC_FW-1:0] {
        FUNC_PUT     = 2'd0,
        FUNC_NEWLINE = 2'd1,
        FUNC_TAB     = 2'd2,
        FUNC_READ    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_NEWLINE,
        ST_BLANK,
        ST_MARK,
        ST_READ,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_PUT,
        DP_NEWLINE,
        DP_BLANK,
        DP_MARK,
        DP_READ
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic sweep_row_last;
        logic sweep_all_last;
        logic cnt_zero;
        logic out_busy;
    } t_dp_status;

endpackage

>>> hw/rtl/tcw_datapath.sv
// Console datapath: character store, cursor, tab counter, row offset and result register.
`include "assert_macros.svh"

module tcw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_status           o_sts,
    input  logic [tcw_pkg::FUNC_FW-1:0]   i_func,
    input  logic [tcw_pkg::CHAR_FW-1:0]   i_char_code,
    input  logic [tcw_pkg::ROW_FW-1:0]    i_read_row,
    input  logic [tcw_pkg::COL_FW-1:0]    i_read_col,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [tcw_pkg::CHAR_FW-1:0]   o_cell_char,
    output logic [tcw_pkg::ROW_FW-1:0]    o_cursor_row,
    output logic [tcw_pkg::COL_FW-1:0]    o_cursor_col
);

    logic [tcw_pkg::CHAR_FW-1:0] mem [tcw_pkg::CELLS];

    tcw_pkg::t_func              r_func;
    logic [tcw_pkg::CHAR_FW-1:0] r_char;
    logic [tcw_pkg::ROW_FW-1:0]  r_read_row;
    logic [tcw_pkg::COL_FW-1:0]  r_read_col;
    logic [tcw_pkg::TAB_W-1:0]   r_cnt,   n_cnt;
    logic [tcw_pkg::ROW_W-1:0]   r_row,   n_row;
    logic [tcw_pkg::COL_W-1:0]   r_col,   n_col;
    logic [tcw_pkg::ROW_W-1:0]   r_top,   n_top;
    logic [tcw_pkg::TAB_W-1:0]   r_tab,   n_tab;
    logic [tcw_pkg::ADDR_W-1:0]  r_sweep, n_sweep;
    logic                        r_out_valid, n_out_valid;
    logic [tcw_pkg::CHAR_FW-1:0] r_rdata;
    logic [tcw_pkg::CHAR_FW-1:0] r_out_char;
    logic [tcw_pkg::ROW_FW-1:0]  r_out_row;
    logic [tcw_pkg::COL_FW-1:0]  r_out_col;

    logic                        col_last;
    logic                        row_last;
    logic                        rd_in_range;
    logic [tcw_pkg::ROW_W-1:0]   row_sel;
    logic [tcw_pkg::COL_W-1:0]   col_sel;
    logic [tcw_pkg::ROW_W:0]     phys_sum;
    logic [tcw_pkg::ROW_W-1:0]   phys_row;
    logic [tcw_pkg::ADDR_W-1:0]  cell_addr;
    logic                        we;
    logic [tcw_pkg::ADDR_W-1:0]  waddr;
    logic [tcw_pkg::CHAR_FW-1:0] wdata;
    logic [tcw_pkg::ADDR_W-1:0]  raddr;

    assign col_last    = (r_col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
    assign row_last    = (r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign rd_in_range = (32'(r_read_row) < 32'(tcw_pkg::ROWS)) &&
                         (32'(r_read_col) < 32'(tcw_pkg::COLS));

    // Logical row to physical row: the grid is a ring of rows starting at r_top.
    always_comb begin
        row_sel  = (i_cmd.op == tcw_pkg::DP_READ) ? tcw_pkg::ROW_W'(r_read_row) : r_row;
        case (i_cmd.op)
            tcw_pkg::DP_BLANK: col_sel = r_sweep[tcw_pkg::COL_W-1:0];
            tcw_pkg::DP_READ:  col_sel = tcw_pkg::COL_W'(r_read_col);
            default:           col_sel = r_col;
        endcase
        phys_sum = (tcw_pkg::ROW_W + 1)'(r_top) + (tcw_pkg::ROW_W + 1)'(row_sel);
        if (phys_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) begin
            phys_row = tcw_pkg::ROW_W'(phys_sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS));
        end else begin
            phys_row = tcw_pkg::ROW_W'(phys_sum);
        end
        cell_addr = tcw_pkg::ADDR_W'(phys_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                  + tcw_pkg::ADDR_W'(col_sel);
        raddr     = rd_in_range ? cell_addr : '0;
    end

    always_comb begin
        we    = 1'b0;
        waddr = cell_addr;
        wdata = tcw_pkg::CH_BLANK;
        case (i_cmd.op)
            tcw_pkg::DP_CLEAR: begin
                we    = 1'b1;
                waddr = r_sweep;
                wdata = (r_sweep == '0) ? tcw_pkg::CH_MARK : tcw_pkg::CH_BLANK;
            end
            tcw_pkg::DP_PUT: begin
                we    = 1'b1;
                wdata = r_char;
            end
            tcw_pkg::DP_BLANK: begin
                we    = 1'b1;
            end
            tcw_pkg::DP_MARK: begin
                we    = 1'b1;
                wdata = tcw_pkg::CH_MARK;
            end
            default: begin
                we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.op == tcw_pkg::DP_READ) begin
            r_rdata <= mem[raddr];
        end
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_tab       = r_tab;
        n_sweep     = r_sweep;
        n_out_valid = i_cmd.out_load | (r_out_valid & i_stall);
        case (i_cmd.op)
            tcw_pkg::DP_LOAD: begin
                case (tcw_pkg::t_func'(i_func))
                    tcw_pkg::FUNC_PUT: n_cnt = tcw_pkg::TAB_W'(1);
                    tcw_pkg::FUNC_TAB: n_cnt = r_tab;
                    default:           n_cnt = '0;
                endcase
            end
            tcw_pkg::DP_CLEAR: begin
                n_sweep = r_sweep + tcw_pkg::ADDR_W'(1);
            end
            tcw_pkg::DP_PUT: begin
                n_cnt = r_cnt - tcw_pkg::TAB_W'(1);
                // On the last column hold; the newline that follows zeroes it.
                if (!col_last) begin
                    n_col = r_col + tcw_pkg::COL_W'(1);
                end
                if (r_tab == tcw_pkg::TAB_W'(1)) begin
                    n_tab = tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH);
                end else begin
                    n_tab = r_tab - tcw_pkg::TAB_W'(1);
                end
            end
            tcw_pkg::DP_NEWLINE: begin
                n_tab   = tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH);
                n_col   = '0;
                n_sweep = '0;
                if (row_last) begin
                    // Scroll: the old top row becomes the new bottom row.
                    if (r_top == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                        n_top = '0;
                    end else begin
                        n_top = r_top + tcw_pkg::ROW_W'(1);
                    end
                end else begin
                    n_row = r_row + tcw_pkg::ROW_W'(1);
                end
            end
            tcw_pkg::DP_BLANK: begin
                n_sweep = r_sweep + tcw_pkg::ADDR_W'(1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_tab       <= tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH);
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_tab       <= n_tab;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (i_cmd.op == tcw_pkg::DP_LOAD) begin
            r_func     <= tcw_pkg::t_func'(i_func);
            r_char     <= (tcw_pkg::t_func'(i_func) == tcw_pkg::FUNC_TAB) ?
                          tcw_pkg::CH_BLANK : i_char_code;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
        end
        if (i_cmd.out_load) begin
            r_out_char <= (r_func == tcw_pkg::FUNC_READ && rd_in_range) ? r_rdata : '0;
            r_out_row  <= tcw_pkg::ROW_FW'(r_row);
            r_out_col  <= tcw_pkg::COL_FW'(r_col);
        end
    end

    assign o_sts.col_last       = col_last;
    assign o_sts.row_last       = row_last;
    assign o_sts.sweep_row_last = (r_sweep == tcw_pkg::ADDR_W'(tcw_pkg::COLS - 1));
    assign o_sts.sweep_all_last = (r_sweep == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
    assign o_sts.cnt_zero       = (r_cnt == '0);
    assign o_sts.out_busy       = r_out_valid & i_stall;

    assign o_valid      = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

    `TCW_ASSERT(a_row_range, r_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1), "cursor row out of grid")
    `TCW_ASSERT(a_top_range, r_top <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1), "row offset out of grid")
    `TCW_ASSERT_NEXT(a_scroll_row, (i_cmd.op == tcw_pkg::DP_NEWLINE) && row_last, (r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) && (r_sweep == '0), "scroll did not park cursor on bottom row")

endmodule

>>> hw/rtl/tcw_ctrl.sv
// Console controller: state machine that sequences the datapath per item.
`include "assert_macros.svh"

module tcw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [tcw_pkg::FUNC_FW-1:0] i_func,
    output logic                        o_stall,
    output tcw_pkg::t_dp_cmd            o_cmd,
    input  tcw_pkg::t_dp_status         i_sts
);

    tcw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = tcw_pkg::DP_NOP;
        o_cmd.out_load = 1'b0;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_cmd.op = tcw_pkg::DP_CLEAR;
                if (i_sts.sweep_all_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = tcw_pkg::DP_LOAD;
                    case (tcw_pkg::t_func'(i_func))
                        tcw_pkg::FUNC_NEWLINE: n_state = tcw_pkg::ST_NEWLINE;
                        tcw_pkg::FUNC_READ:    n_state = tcw_pkg::ST_READ;
                        default:               n_state = tcw_pkg::ST_PUT;
                    endcase
                end
            end
            tcw_pkg::ST_PUT: begin
                o_cmd.op = tcw_pkg::DP_PUT;
                n_state  = i_sts.col_last ? tcw_pkg::ST_NEWLINE : tcw_pkg::ST_MARK;
            end
            tcw_pkg::ST_NEWLINE: begin
                o_cmd.op = tcw_pkg::DP_NEWLINE;
                n_state  = i_sts.row_last ? tcw_pkg::ST_BLANK : tcw_pkg::ST_MARK;
            end
            tcw_pkg::ST_BLANK: begin
                o_cmd.op = tcw_pkg::DP_BLANK;
                if (i_sts.sweep_row_last) begin
                    n_state = tcw_pkg::ST_MARK;
                end
            end
            tcw_pkg::ST_MARK: begin
                // Loop back for the remaining spaces of a tab.
                o_cmd.op = tcw_pkg::DP_MARK;
                n_state  = i_sts.cnt_zero ? tcw_pkg::ST_DONE : tcw_pkg::ST_PUT;
            end
            tcw_pkg::ST_READ: begin
                o_cmd.op = tcw_pkg::DP_READ;
                n_state  = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != tcw_pkg::ST_IDLE);

    `TCW_ASSERT_NEXT(a_put_then, o_cmd.op == tcw_pkg::DP_PUT, (o_cmd.op == tcw_pkg::DP_MARK) || (o_cmd.op == tcw_pkg::DP_NEWLINE), "put not followed by mark or newline")
    `TCW_ASSERT_NEXT(a_load_busy, o_cmd.op == tcw_pkg::DP_LOAD, o_stall, "item loaded but input not held off")
    `TCW_ASSERT_SAME(a_load_only_done, o_cmd.out_load, (r_state == tcw_pkg::ST_DONE) && !i_sts.out_busy, "result loaded outside done state")

endmodule

>>> hw/rtl/text_console_writer_top.sv
// Top level of the text console: controller and datapath.
//
// Input channel: i_valid / o_stall carry one command item (i_func, i_char_code,
// i_read_row, i_read_col). Output channel: o_valid / i_stall carry one result
// item per command (o_cell_char, o_cursor_row, o_cursor_col).
// Items are processed one at a time; o_stall is low only while idle.
// States per item, from the idle state that accepts it: put: idle, put, mark,
//   done; newline: idle, newline, mark, done; read: idle, read, done; tab:
//   idle, put and mark per space (up to 8), done. A wrap adds one newline
//   step; a scroll adds a pass that blanks the new bottom row. The grid is a
//   ring of rows, so a scroll moves no data; the store has a single write port.
// After reset a clearing pass writes all 2000 cells (spaces, underscore at
// cell zero), one per cycle; o_stall stays high until the pass ends.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, the result holds and the next item finishes its work
// and then waits for the register before the block returns to idle.
`include "assert_macros.svh"

module text_console_writer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tcw_pkg::FUNC_FW-1:0] i_func,
    input  logic [tcw_pkg::CHAR_FW-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_FW-1:0]  i_read_row,
    input  logic [tcw_pkg::COL_FW-1:0]  i_read_col,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tcw_pkg::CHAR_FW-1:0] o_cell_char,
    output logic [tcw_pkg::ROW_FW-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_FW-1:0]  o_cursor_col
);

    tcw_pkg::t_dp_cmd    cmd;
    tcw_pkg::t_dp_status sts;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    tcw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_cell_char  (o_cell_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule
